>>> src/udpc_pkg.sv
package udpc_pkg;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_PORT    = 1'b1;

    localparam logic [15:0] ETH_TYPE_IP        = 16'h0800;
    localparam logic [7:0]  IP_VER_HLEN        = 8'h45;
    localparam logic [7:0]  IP_PROTO_UDP       = 8'd17;
    localparam logic [15:0] FRAGMENT_MASK      = 16'h3FFF;
    localparam logic [15:0] SUM_ALL_ONES       = 16'hFFFF;
    localparam logic [15:0] POSITION_SATURATED = 16'hFFFF;

    localparam logic [3:0] RSN_OK          = 4'd0;
    localparam logic [3:0] RSN_SHORT       = 4'd1;
    localparam logic [3:0] RSN_ETHERTYPE   = 4'd2;
    localparam logic [3:0] RSN_VERSION     = 4'd3;
    localparam logic [3:0] RSN_PROTOCOL    = 4'd4;
    localparam logic [3:0] RSN_FRAGMENT    = 4'd5;
    localparam logic [3:0] RSN_HEADER_SUM  = 4'd6;
    localparam logic [3:0] RSN_ADDRESS     = 4'd7;
    localparam logic [3:0] RSN_TOTAL_SMALL = 4'd8;
    localparam logic [3:0] RSN_TOTAL_LONG  = 4'd9;
    localparam logic [3:0] RSN_UDP_SMALL   = 4'd10;
    localparam logic [3:0] RSN_UDP_LENGTH  = 4'd11;
    localparam logic [3:0] RSN_PORT        = 4'd12;
    localparam logic [3:0] RSN_UDP_SUM     = 4'd13;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic        accepted;
        logic [3:0]  reject_reason;
        logic [31:0] source_address;
        logic [47:0] source_mac;
        logic [15:0] source_port;
        logic [15:0] data_bytes;
    } t_out_beat;

    // Per-frame parse state; also the snapshot handed to the judge stage.
    typedef struct packed {
        logic [15:0] byte_count;
        logic [15:0] header_sum;
        logic [15:0] datagram_sum;
        logic [7:0]  pending_high;
        logic [15:0] ethertype;
        logic [7:0]  version;
        logic [7:0]  protocol;
        logic [15:0] fragment;
        logic [15:0] ip_total;
        logic [31:0] dest_address;
        logic [31:0] src_address;
        logic [47:0] src_mac;
        logic [15:0] udp_hdr_len;
        logic [15:0] dest_port;
        logic [15:0] src_port;
        logic [15:0] udp_hdr_sum;
    } t_frame_state;

    // One's-complement add with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        logic [16:0] f;
        s = {1'b0, a} + {1'b0, b};
        f = {1'b0, s[15:0]} + {16'd0, s[16]};
        return f[15:0];
    endfunction

endpackage

>>> src/udpc_parse.sv
module udpc_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_beat_en,
    input  udpc_pkg::t_in_beat    i_beat,
    input  logic                  i_snap_take,
    output logic                  o_snap_valid,
    output udpc_pkg::t_frame_state o_snap
);
    import udpc_pkg::*;

    t_frame_state r_st, n_st;
    t_frame_state r_snap;
    logic         r_snap_vld;

    logic [15:0] pos;
    logic [7:0]  b;
    logic [16:0] pos_ext;
    logic [16:0] frame_end;
    logic [15:0] word;

    always_comb begin
        pos       = r_st.byte_count;
        b         = i_beat.frame_byte;
        pos_ext   = {1'b0, pos};
        frame_end = 17'd14 + {1'b0, r_st.ip_total};
        word      = {r_st.pending_high, b};
        n_st      = r_st;
        if (pos != POSITION_SATURATED) begin
            // capture header fields
            if (pos >= 16'd6 && pos <= 16'd11) begin
                n_st.src_mac = {r_st.src_mac[39:0], b};
            end else if (pos == 16'd12 || pos == 16'd13) begin
                n_st.ethertype = {r_st.ethertype[7:0], b};
            end else if (pos == 16'd14) begin
                n_st.version = b;
            end else if (pos == 16'd16 || pos == 16'd17) begin
                n_st.ip_total = {r_st.ip_total[7:0], b};
            end else if (pos == 16'd20 || pos == 16'd21) begin
                n_st.fragment = {r_st.fragment[7:0], b};
            end else if (pos == 16'd23) begin
                n_st.protocol = b;
            end else if (pos >= 16'd26 && pos <= 16'd29) begin
                n_st.src_address = {r_st.src_address[23:0], b};
            end else if (pos >= 16'd30 && pos <= 16'd33) begin
                n_st.dest_address = {r_st.dest_address[23:0], b};
            end else if (pos == 16'd34 || pos == 16'd35) begin
                n_st.src_port = {r_st.src_port[7:0], b};
            end else if (pos == 16'd36 || pos == 16'd37) begin
                n_st.dest_port = {r_st.dest_port[7:0], b};
            end else if (pos == 16'd38 || pos == 16'd39) begin
                n_st.udp_hdr_len = {r_st.udp_hdr_len[7:0], b};
            end else if (pos == 16'd40 || pos == 16'd41) begin
                n_st.udp_hdr_sum = {r_st.udp_hdr_sum[7:0], b};
            end

            // running sums; end of datagram uses the total length captured earlier
            if (pos[0] && pos >= 16'd15 && pos <= 16'd33) begin
                n_st.header_sum = ones_add(r_st.header_sum, word);
            end
            if (pos >= 16'd26 && pos <= 16'd33) begin
                if (pos[0]) begin
                    n_st.datagram_sum = ones_add(r_st.datagram_sum, word);
                end
            end else if (pos >= 16'd34 && pos_ext < frame_end) begin
                if (pos[0]) begin
                    n_st.datagram_sum = ones_add(r_st.datagram_sum, word);
                end else if (pos_ext + 17'd1 == frame_end) begin
                    n_st.datagram_sum = ones_add(r_st.datagram_sum, {b, 8'h00});
                end
            end
            if (!pos[0]) begin
                n_st.pending_high = b;
            end
            n_st.byte_count = pos + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= '0;
            r_snap_vld <= 1'b0;
        end else begin
            if (i_beat_en) begin
                // clear the frame state after the last beat
                r_st <= i_beat.last_byte ? '0 : n_st;
            end
            if (i_beat_en && i_beat.last_byte) begin
                r_snap_vld <= 1'b1;
            end else if (i_snap_take) begin
                r_snap_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat_en && i_beat.last_byte) begin
            r_snap <= n_st;
        end
    end

    assign o_snap_valid = r_snap_vld;
    assign o_snap       = r_snap;

endmodule

>>> src/udpc_judge.sv
module udpc_judge (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [31:0]            i_local_address,
    input  logic [15:0]            i_local_port,
    input  logic                   i_snap_valid,
    input  udpc_pkg::t_frame_state i_snap,
    output logic                   o_snap_take,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output udpc_pkg::t_out_beat    o_out_beat
);
    import udpc_pkg::*;

    t_out_beat   r_out, n_out;
    logic        r_out_vld;
    logic [3:0]  reason;
    logic [15:0] udp_len;
    logic [15:0] room;
    logic [15:0] sum_a;
    logic [15:0] sum_b;

    always_comb begin
        udp_len = i_snap.ip_total - 16'd20;
        room    = i_snap.byte_count - 16'd34;
        sum_a   = ones_add(i_snap.datagram_sum, {8'd0, IP_PROTO_UDP});
        sum_b   = ones_add(sum_a, udp_len);

        // first failing check wins
        if (i_snap.byte_count < 16'd34) begin
            reason = RSN_SHORT;
        end else if (i_snap.ethertype != ETH_TYPE_IP) begin
            reason = RSN_ETHERTYPE;
        end else if (i_snap.version != IP_VER_HLEN) begin
            reason = RSN_VERSION;
        end else if (i_snap.protocol != IP_PROTO_UDP) begin
            reason = RSN_PROTOCOL;
        end else if ((i_snap.fragment & FRAGMENT_MASK) != 16'd0) begin
            reason = RSN_FRAGMENT;
        end else if (i_snap.header_sum != SUM_ALL_ONES) begin
            reason = RSN_HEADER_SUM;
        end else if (i_local_address != 32'd0 && i_snap.dest_address != i_local_address) begin
            reason = RSN_ADDRESS;
        end else if (i_snap.ip_total < 16'd20) begin
            reason = RSN_TOTAL_SMALL;
        end else if (udp_len > room) begin
            reason = RSN_TOTAL_LONG;
        end else if (udp_len < 16'd8) begin
            reason = RSN_UDP_SMALL;
        end else if (i_snap.udp_hdr_len != udp_len) begin
            reason = RSN_UDP_LENGTH;
        end else if (i_snap.dest_port != i_local_port) begin
            reason = RSN_PORT;
        end else if (i_snap.udp_hdr_sum != 16'd0 && sum_b != SUM_ALL_ONES) begin
            reason = RSN_UDP_SUM;
        end else begin
            reason = RSN_OK;
        end

        n_out = '0;
        n_out.reject_reason = reason;
        if (reason == RSN_OK) begin
            n_out.accepted       = 1'b1;
            n_out.source_address = i_snap.src_address;
            n_out.source_mac     = i_snap.src_mac;
            n_out.source_port    = i_snap.src_port;
            n_out.data_bytes     = i_snap.udp_hdr_len - 16'd8;
        end
    end

    assign o_snap_take = i_snap_valid && (!r_out_vld || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_snap_take) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out;

endmodule

>>> src/udp_ipv4_receive_checker.sv
// UDP/IPv4 receive checker. Takes one ethernet frame byte per cycle, starting at the
// destination MAC, with last_byte on the final byte, and gives one result per frame:
// accept with sender address, MAC, port and payload length, or the first failed check.
// Every byte is handled in the parse stage (one header-sum add and one datagram-sum
// add beside the field capture), so a new byte is taken every cycle unless stalled; the
// result of a frame passes from its last byte through a snapshot register and the
// judge stage's output register. Input stalls only when a finished frame waits in the
// snapshot while the output register is full and stalled. Configure only while idle.
module udp_ipv4_receive_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  udpc_pkg::t_in_beat                i_in_beat,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output udpc_pkg::t_out_beat               o_out_beat,
    input  logic                              i_cfg_wr_en,
    input  logic [udpc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [31:0]                       i_cfg_wr_data
);
    import udpc_pkg::*;

    logic [31:0]  r_local_address;
    logic [15:0]  r_local_port;
    logic         beat_en;
    logic         snap_valid;
    logic         snap_take;
    t_frame_state snap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_address <= '0;
            r_local_port    <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_LOCAL_ADDRESS: r_local_address <= i_cfg_wr_data;
                CFG_LOCAL_PORT:    r_local_port    <= i_cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    // hold input while a finished frame cannot move on
    assign o_in_stall = snap_valid && !snap_take;
    assign beat_en    = i_in_valid && !o_in_stall;

    udpc_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_en    (beat_en),
        .i_beat       (i_in_beat),
        .i_snap_take  (snap_take),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    udpc_judge u_judge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_local_address (r_local_address),
        .i_local_port    (r_local_port),
        .i_snap_valid    (snap_valid),
        .i_snap          (snap),
        .o_snap_take     (snap_take),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_beat      (o_out_beat)
    );

endmodule

>>> tb/sv/udp_ipv4_receive_checker_test.sv
`timescale 1ns / 1ps

module udp_ipv4_receive_checker_test;
    import udpc_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    typedef enum int {
        DMG_BIT, DMG_CUT, DMG_ETHERTYPE, DMG_VERSION, DMG_PROTOCOL,
        DMG_FRAGMENT, DMG_TOTAL, DMG_UDP_LENGTH, DMG_PAYLOAD, DMG_TAIL
    } t_damage;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    t_in_beat               i_in_beat = '0;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_LOCAL_ADDRESS;
    logic [31:0]            i_cfg_wr_data = '0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    t_out_beat              o_out_beat;

    // predictor copy of the filter registers and of the frame being parsed
    logic [31:0]  filter_address = '0;
    logic [15:0]  filter_port = '0;
    t_frame_state parse = '0;
    t_out_beat    verdict_q[$];

    logic [7:0]   frame_buf[$];
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;
    int           mismatch_count = 0;
    int           frames_sent = 0;
    int           bytes_sent = 0;
    int           results_seen = 0;
    int           accepted_seen = 0;
    logic [15:0]  reasons_hit = '0;

    udp_ipv4_receive_checker dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_beat(i_in_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_beat(o_out_beat),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic void predict_beat(input logic [7:0] b, input logic last);
        t_out_beat   v;
        int unsigned p;
        int unsigned dgram_end;
        logic [15:0] udp_len;
        logic [3:0]  why;
        p = parse.byte_count;
        // bytes past the saturated count are neither captured nor summed
        if (p < POSITION_SATURATED) begin
            if (p >= 6 && p <= 11) parse.src_mac = {parse.src_mac[39:0], b};
            else if (p == 12 || p == 13) parse.ethertype = {parse.ethertype[7:0], b};
            else if (p == 14) parse.version = b;
            else if (p == 16 || p == 17) parse.ip_total = {parse.ip_total[7:0], b};
            else if (p == 20 || p == 21) parse.fragment = {parse.fragment[7:0], b};
            else if (p == 23) parse.protocol = b;
            else if (p >= 26 && p <= 29) parse.src_address = {parse.src_address[23:0], b};
            else if (p >= 30 && p <= 33) parse.dest_address = {parse.dest_address[23:0], b};
            else if (p == 34 || p == 35) parse.src_port = {parse.src_port[7:0], b};
            else if (p == 36 || p == 37) parse.dest_port = {parse.dest_port[7:0], b};
            else if (p == 38 || p == 39) parse.udp_hdr_len = {parse.udp_hdr_len[7:0], b};
            else if (p == 40 || p == 41) parse.udp_hdr_sum = {parse.udp_hdr_sum[7:0], b};

            dgram_end = 14 + parse.ip_total;
            if (p[0] && p >= 15 && p <= 33)
                parse.header_sum = fold_add(parse.header_sum, {parse.pending_high, b});
            if (p >= 26 && p <= 33) begin
                if (p[0]) parse.datagram_sum = fold_add(parse.datagram_sum, {parse.pending_high, b});
            end else if (p >= 34 && p < dgram_end) begin
                if (p[0])
                    parse.datagram_sum = fold_add(parse.datagram_sum, {parse.pending_high, b});
                else if (p + 1 == dgram_end)
                    parse.datagram_sum = fold_add(parse.datagram_sum, {b, 8'h00});
            end
            if (!p[0]) parse.pending_high = b;
            parse.byte_count = parse.byte_count + 16'd1;
        end
        if (!last) return;

        p = parse.byte_count;
        udp_len = parse.ip_total - 16'd20;
        if (p < 34) why = RSN_SHORT;
        else if (parse.ethertype != ETH_TYPE_IP) why = RSN_ETHERTYPE;
        else if (parse.version != IP_VER_HLEN) why = RSN_VERSION;
        else if (parse.protocol != IP_PROTO_UDP) why = RSN_PROTOCOL;
        else if ((parse.fragment & FRAGMENT_MASK) != 16'd0) why = RSN_FRAGMENT;
        else if (parse.header_sum != SUM_ALL_ONES) why = RSN_HEADER_SUM;
        else if (filter_address != 32'd0 && parse.dest_address != filter_address)
            why = RSN_ADDRESS;
        else if (parse.ip_total < 16'd20) why = RSN_TOTAL_SMALL;
        else if (udp_len > p - 34) why = RSN_TOTAL_LONG;
        else if (udp_len < 16'd8) why = RSN_UDP_SMALL;
        else if (parse.udp_hdr_len != udp_len) why = RSN_UDP_LENGTH;
        else if (parse.dest_port != filter_port) why = RSN_PORT;
        else if (parse.udp_hdr_sum != 16'd0 &&
                 fold_add(fold_add(parse.datagram_sum, {8'd0, IP_PROTO_UDP}), udp_len)
                 != SUM_ALL_ONES)
            why = RSN_UDP_SUM;
        else why = RSN_OK;

        v = '0;
        v.reject_reason = why;
        if (why == RSN_OK) begin
            v.accepted = 1'b1;
            v.source_address = parse.src_address;
            v.source_mac = parse.src_mac;
            v.source_port = parse.src_port;
            v.data_bytes = parse.udp_hdr_len - 16'd8;
        end
        verdict_q.push_back(v);
        parse = '0;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatch_count < 40)
            $display("MISMATCH at result %0d: %s got %0h want %0h", results_seen, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                flag_mismatch("result with nothing pending", 64'(o_out_beat.reject_reason),
                              64'd0);
            end else begin
                want = verdict_q.pop_front();
                reasons_hit[want.reject_reason] = 1'b1;
                if (want.accepted) accepted_seen++;
                if (o_out_beat.accepted !== want.accepted)
                    flag_mismatch("accepted", 64'(o_out_beat.accepted), 64'(want.accepted));
                if (o_out_beat.reject_reason !== want.reject_reason)
                    flag_mismatch("reject_reason", 64'(o_out_beat.reject_reason),
                                  64'(want.reject_reason));
                if (o_out_beat.source_address !== want.source_address)
                    flag_mismatch("source_address", 64'(o_out_beat.source_address),
                                  64'(want.source_address));
                if (o_out_beat.source_mac !== want.source_mac)
                    flag_mismatch("source_mac", 64'(o_out_beat.source_mac),
                                  64'(want.source_mac));
                if (o_out_beat.source_port !== want.source_port)
                    flag_mismatch("source_port", 64'(o_out_beat.source_port),
                                  64'(want.source_port));
                if (o_out_beat.data_bytes !== want.data_bytes)
                    flag_mismatch("data_bytes", 64'(o_out_beat.data_bytes),
                                  64'(want.data_bytes));
            end
        end
    end

    // end the run if no beat moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat moved in %0d cycles", QUIET_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= {b, last};
        do @(posedge i_clk); while (o_in_stall);
        predict_beat(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[k]) send_beat(frame_buf[k], k == frame_buf.size() - 1);
        frames_sent++;
    endtask

    // hold off the sender until every pending verdict is out, then idle a while
    task automatic settle(input int extra);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic set_filter(input logic [31:0] addr, input logic [15:0] port);
        settle(6);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_LOCAL_ADDRESS;
        i_cfg_wr_data <= addr;
        @(posedge i_clk);
        i_cfg_index <= CFG_LOCAL_PORT;
        i_cfg_wr_data <= {16'd0, port};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        filter_address = addr;
        filter_port = port;
    endtask

    function automatic void put16(input int at, input logic [15:0] v);
        frame_buf[at] = v[15:8];
        frame_buf[at + 1] = v[7:0];
    endfunction

    function automatic void push16(input logic [15:0] v);
        frame_buf.push_back(v[15:8]);
        frame_buf.push_back(v[7:0]);
    endfunction

    function automatic void cut_to(input int n);
        while (frame_buf.size() > n) void'(frame_buf.pop_back());
    endfunction

    function automatic void seal_ip();
        logic [15:0] s;
        s = 16'd0;
        put16(24, 16'd0);
        for (int i = 14; i < 34; i += 2) s = fold_add(s, {frame_buf[i], frame_buf[i + 1]});
        put16(24, ~s);
    endfunction

    function automatic void seal_udp();
        logic [15:0] s;
        logic [15:0] ulen;
        logic [15:0] c;
        logic [7:0]  lo;
        int          tail;
        put16(40, 16'd0);
        ulen = {frame_buf[38], frame_buf[39]};
        tail = 34 + int'(ulen);
        s = 16'd0;
        for (int i = 26; i < 34; i += 2) s = fold_add(s, {frame_buf[i], frame_buf[i + 1]});
        for (int i = 34; i < tail && i < frame_buf.size(); i += 2) begin
            lo = (i + 1 < tail && i + 1 < frame_buf.size()) ? frame_buf[i + 1] : 8'h00;
            s = fold_add(s, {frame_buf[i], lo});
        end
        s = fold_add(s, {8'd0, IP_PROTO_UDP});
        s = fold_add(s, ulen);
        c = ~s;
        put16(40, (c == 16'd0) ? SUM_ALL_ONES : c);
    endfunction

    // well-formed frame: random MACs, sender, ids and payload
    function automatic void build_frame(input logic [31:0] dst, input logic [15:0] dport,
                                        input int plen, input int pad, input bit with_sum);
        logic [15:0] ulen;
        ulen = 16'(plen + 8);
        frame_buf.delete();
        repeat (12) frame_buf.push_back(8'($urandom));
        push16(ETH_TYPE_IP);
        frame_buf.push_back(IP_VER_HLEN);
        frame_buf.push_back(8'($urandom));
        push16(ulen + 16'd20);
        push16(16'($urandom));
        push16({2'($urandom), 14'd0});
        frame_buf.push_back(8'($urandom));
        frame_buf.push_back(IP_PROTO_UDP);
        push16(16'd0);
        push16(16'($urandom));
        push16(16'($urandom));
        push16(dst[31:16]);
        push16(dst[15:0]);
        push16(16'($urandom));
        push16(dport);
        push16(ulen);
        push16(16'd0);
        repeat (plen + pad) frame_buf.push_back(8'($urandom));
        seal_ip();
        if (with_sum) seal_udp();
    endfunction

    task automatic test_accepts();
        set_filter(32'hC0A8_0105, 16'd5000);
        build_frame(32'hC0A8_0105, 16'd5000, 0, 0, 1'b1);
        send_frame();
        build_frame(32'hC0A8_0105, 16'd5000, 5, 0, 1'b1);
        send_frame();
        build_frame(32'hC0A8_0105, 16'd5000, 1, 3, 1'b1);
        send_frame();
        // zero checksum field skips the datagram sum
        build_frame(32'hC0A8_0105, 16'd5000, 2, 1, 1'b0);
        send_frame();
    endtask

    task automatic test_short_frames();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        cut_to(1);
        send_frame();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        cut_to(33);
        send_frame();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        cut_to(34);
        send_frame();
    endtask

    task automatic test_header_rejects();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        put16(12, 16'h86DD);
        send_frame();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        frame_buf[14] = 8'h46;
        seal_ip();
        send_frame();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        frame_buf[23] = 8'd6;
        seal_ip();
        send_frame();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        put16(20, 16'h2001);
        seal_ip();
        send_frame();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        frame_buf[24] = frame_buf[24] ^ 8'h01;
        send_frame();
    endtask

    task automatic test_length_rejects();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        put16(16, 16'd19);
        seal_ip();
        send_frame();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        put16(16, 16'hFFFF);
        seal_ip();
        send_frame();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        put16(16, 16'd24);
        seal_ip();
        send_frame();
        build_frame(filter_address, filter_port, 0, 0, 1'b1);
        put16(38, 16'd17);
        send_frame();
    endtask

    task automatic test_filter_rejects();
        set_filter(32'h0A00_0001, 16'd53);
        build_frame(32'h0A00_0002, 16'd53, 0, 0, 1'b1);
        send_frame();
        build_frame(32'h0A00_0001, 16'd54, 0, 0, 1'b1);
        send_frame();
        build_frame(32'h0A00_0001, 16'd53, 4, 0, 1'b1);
        frame_buf[45] = frame_buf[45] ^ 8'h80;
        send_frame();
        // zero address takes any destination
        set_filter(32'h0, 16'hFFFF);
        build_frame($urandom, 16'hFFFF, 0, 0, 1'b1);
        send_frame();
    endtask

    task automatic test_extremes();
        logic [7:0] fill;
        set_filter(32'hFFFF_FFFF, 16'h0000);
        for (int n = 0; n < 2; n++) begin
            fill = (n == 0) ? 8'h00 : 8'hFF;
            build_frame(32'hFFFF_FFFF, 16'h0000, 0, 0, 1'b1);
            for (int k = 6; k < 12; k++) frame_buf[k] = fill;
            for (int k = 26; k < 30; k++) frame_buf[k] = fill;
            frame_buf[34] = fill;
            frame_buf[35] = fill;
            seal_ip();
            seal_udp();
            send_frame();
            frame_buf.delete();
            repeat (40) frame_buf.push_back(fill);
            send_frame();
        end
    endtask

    task automatic test_random(input int idle, input int stall, input logic [31:0] addr,
                               input logic [15:0] port, input int frames);
        int          plen;
        int          pad;
        int          pick;
        int          at;
        logic [31:0] dst;
        logic [15:0] dport;
        t_damage     damage;
        set_filter(addr, port);
        idle_pct = idle;
        stall_pct = stall;
        repeat (frames) begin
            plen = ($urandom_range(9) == 0) ? $urandom_range(120, 49) : $urandom_range(24, 0);
            pad = ($urandom_range(3) == 0) ? $urandom_range(20, 1) : 0;
            dst = (addr == 32'd0 || $urandom_range(9) == 0) ? $urandom : addr;
            dport = ($urandom_range(9) == 0) ? 16'($urandom) : port;
            build_frame(dst, dport, plen, pad, $urandom_range(4) != 0);
            pick = $urandom_range(99);
            if (pick >= 65 && pick < 92) begin
                damage = t_damage'($urandom_range(9));
                case (damage)
                    DMG_BIT: begin
                        at = $urandom_range(frame_buf.size() - 1);
                        frame_buf[at] = frame_buf[at] ^ 8'(1 << $urandom_range(7));
                    end
                    DMG_CUT: cut_to($urandom_range(frame_buf.size() - 1, 1));
                    DMG_ETHERTYPE: put16(12, 16'($urandom));
                    DMG_VERSION: begin
                        frame_buf[14] = 8'($urandom);
                        seal_ip();
                    end
                    DMG_PROTOCOL: begin
                        frame_buf[23] = 8'($urandom);
                        seal_ip();
                    end
                    DMG_FRAGMENT: begin
                        put16(20, 16'($urandom));
                        seal_ip();
                    end
                    DMG_TOTAL: begin
                        put16(16, 16'($urandom_range(120)));
                        seal_ip();
                    end
                    DMG_UDP_LENGTH: put16(38, 16'($urandom_range(120)));
                    DMG_PAYLOAD: begin
                        at = 34 + $urandom_range(plen + 7);
                        frame_buf[at] = frame_buf[at] ^ 8'h01;
                    end
                    default: repeat ($urandom_range(30, 1)) frame_buf.push_back(8'($urandom));
                endcase
            end else if (pick >= 92) begin
                // noise, sometimes with a plausible start
                frame_buf.delete();
                repeat ($urandom_range(80, 1)) frame_buf.push_back(8'($urandom));
                if ($urandom_range(1) == 1 && frame_buf.size() > 15) begin
                    put16(12, ETH_TYPE_IP);
                    frame_buf[14] = IP_VER_HLEN;
                end
            end
            send_frame();
            if ($urandom_range(9) == 0) settle(0);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_accepts();
        test_short_frames();
        test_header_rejects();
        test_length_rejects();
        test_filter_rejects();
        test_extremes();
        test_random(0, 0, 32'h0, 16'($urandom), 2);
        test_random(49, 0, $urandom, 16'hFFFF, 2);
        test_random(0, 49, 32'hFFFF_FFFF, 16'h0000, 2);
        test_random(35, 35, $urandom, 16'($urandom), 2);

        settle(8);
        $display("summary: %0d frames in %0d bytes, %0d verdicts checked, %0d accepted",
                 frames_sent, bytes_sent, results_seen, accepted_seen);
        $display("summary: reject reasons seen %b, one bit per reason code", reasons_hit);
        if (mismatch_count == 0 && verdict_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> sim.f
src/udpc_pkg.sv
src/udpc_parse.sv
src/udpc_judge.sv
src/udp_ipv4_receive_checker.sv
tb/sv/udp_ipv4_receive_checker_test.sv
